/* hdl/hrt_pkg.sv */
// Package for the HTTP request tokenizer: sizes, codes, and the types of
// the parser state and of one result item. Depends on nothing else.
package hrt_pkg;

    localparam int METHOD_BUFFER = 16;
    localparam int URI_BUFFER    = 256;
    localparam int BODY_BUFFER   = 1024;
    localparam int LINE_LIMIT    = METHOD_BUFFER + URI_BUFFER + 16;

    localparam int LINE_W = $clog2(LINE_LIMIT + 2);
    localparam int TLEN_W = $clog2((METHOD_BUFFER > URI_BUFFER) ? METHOD_BUFFER : URI_BUFFER);
    localparam int BODY_W = $clog2(BODY_BUFFER);

    localparam int BODY_LEN_W   = 10;
    localparam int BODY_LEN_MAX = (1 << BODY_LEN_W) - 1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [3:0] {
        PH_LINE = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_BODY = 4'b0100,
        PH_BAD  = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        TM_NONE   = 2'd0,
        TM_CR     = 2'd1,
        TM_CRLF   = 2'd2,
        TM_CRLFCR = 2'd3
    } t_term;

    typedef enum logic [1:0] {
        KIND_METHOD = 2'd0,
        KIND_URI    = 2'd1,
        KIND_BODY   = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef struct packed {
        t_phase              phase;
        logic [LINE_W-1:0]   line_length;
        logic [1:0]          token_number;
        logic [TLEN_W-1:0]   token_length;
        logic                inside_token;
        t_term               term;
        logic [BODY_W-1:0]   body_count;
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             data;
        logic                   malformed;
        logic [BODY_LEN_W-1:0]  body_length;
        logic                   last;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:        PH_LINE,
        line_length:  '0,
        token_number: 2'd0,
        token_length: '0,
        inside_token: 1'b0,
        term:         TM_NONE,
        body_count:   '0
    };

endpackage

/* hdl/http_request_tokenizer.sv */
// Top level of the HTTP request tokenizer: input register, parser state,
// result register and handshakes. Depends on hrt_pkg and hrt_parse.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_ready   i_data_byte
//   result   out        o_valid / i_ready   o_result_kind, o_result_byte,
//                                           o_malformed, o_body_length, o_last
//
// One byte per cycle is accepted into the input register while o_ready is high;
// its result, if any, is loaded into the result register when that byte advances.
// The parser state register updates at the same edge as the result register.
// A synchronous active-low reset clears the state to the start of a request.
// When the result is not taken, the input register holds one more byte and
// o_ready drops until the result register frees.
module http_request_tokenizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_result_kind,
    output logic [7:0]                      o_result_byte,
    output logic                            o_malformed,
    output logic [hrt_pkg::BODY_LEN_W-1:0]  o_body_length,
    output logic                            o_last
);
    import hrt_pkg::*;

    logic     r_in_valid;
    logic [7:0] r_in_byte;
    t_state   r_state;
    t_state   n_state;
    logic     r_out_valid;
    t_result  r_out;
    t_result  n_out;
    logic     n_has_result;
    logic     w_advance;

    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    hrt_parse u_parse (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .o_state      (n_state),
        .o_result     (n_out),
        .o_has_result (n_has_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_state     <= n_state;
                r_out_valid <= n_has_result;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_result_byte = r_out.data;
    assign o_malformed   = r_out.malformed;
    assign o_body_length = r_out.body_length;
    assign o_last        = r_out.last;

    a_token_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.token_number <= 2'd2)
        else $error("token count exceeds two");

    a_body_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_state.body_count) <= BODY_BUFFER - 1)
        else $error("body count exceeds cap");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_byte == CH_NUL |=>
            r_state.phase == PH_LINE && r_state.line_length == '0 &&
            r_state.body_count == '0 && o_valid && o_last)
        else $error("request end did not restore state or give status");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last |-> r_out.kind == KIND_STATUS)
        else $error("last flag on a non-status item");

    a_body_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_BODY |-> r_state.phase == PH_BODY)
        else $error("body item outside body phase");

endmodule

/* hdl/hrt_parse.sv */
// Next-state and result logic of the tokenizer for one request byte.
// Purely combinational; depends on hrt_pkg.
module hrt_parse (
    input  hrt_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    output hrt_pkg::t_state  o_state,
    output hrt_pkg::t_result o_result,
    output logic             o_has_result
);
    import hrt_pkg::*;

    logic                 w_crlf;
    logic                 w_space;
    logic                 w_bad_end;
    logic [1:0]           w_tok_after;
    logic [TLEN_W-1:0]    w_cur_len;
    logic [TLEN_W-1:0]    w_limit;
    logic [BODY_W-1:0]    w_len_src;

    always_comb begin
        o_state      = i_state;
        o_result     = '0;
        o_has_result = 1'b0;
        w_crlf       = (i_byte == CH_LF) &&
                       (i_state.term == TM_CR || i_state.term == TM_CRLFCR);
        w_space      = (i_byte == CH_SPACE) || (i_byte >= CH_TAB && i_byte <= CH_CR);
        w_bad_end    = (i_state.phase == PH_LINE) || (i_state.phase == PH_BAD);
        w_tok_after  = i_state.token_number + {1'b0, i_state.inside_token};
        w_cur_len    = i_state.inside_token ? i_state.token_length : '0;
        w_limit      = (i_state.token_number == 2'd0) ? TLEN_W'(METHOD_BUFFER - 1)
                                                       : TLEN_W'(URI_BUFFER - 1);
        w_len_src    = w_bad_end ? '0 : i_state.body_count;

        if (i_byte == CH_NUL) begin
            o_result.kind      = KIND_STATUS;
            o_result.malformed = w_bad_end;
            o_result.last      = 1'b1;
            if (32'(w_len_src) > BODY_LEN_MAX) begin
                o_result.body_length = BODY_LEN_W'(BODY_LEN_MAX);
            end else begin
                o_result.body_length = BODY_LEN_W'(w_len_src);
            end
            o_has_result = 1'b1;
            o_state      = STATE_RESET;
        end else begin
            if (i_byte == CH_CR) begin
                o_state.term = (i_state.term == TM_CRLF) ? TM_CRLFCR : TM_CR;
            end else if (i_byte == CH_LF && i_state.term == TM_CR) begin
                o_state.term = TM_CRLF;
            end else begin
                o_state.term = TM_NONE;
            end

            case (i_state.phase)
                PH_LINE: begin
                    if (w_crlf) begin
                        o_state.token_number = w_tok_after;
                        o_state.inside_token = 1'b0;
                        if (32'(i_state.line_length) >= LINE_LIMIT + 1 ||
                            w_tok_after < 2'd2) begin
                            o_state.phase = PH_BAD;
                        end else begin
                            o_state.phase = PH_HEAD;
                        end
                    end else begin
                        if (32'(i_state.line_length) <= LINE_LIMIT) begin
                            o_state.line_length = i_state.line_length + 1'b1;
                        end
                        if (w_space) begin
                            o_state.token_number = w_tok_after;
                            o_state.inside_token = 1'b0;
                        end else if (i_state.token_number < 2'd2) begin
                            o_state.inside_token = 1'b1;
                            if (w_cur_len >= w_limit) begin
                                o_state.token_length = w_cur_len;
                                o_state.phase        = PH_BAD;
                            end else begin
                                o_state.token_length = w_cur_len + 1'b1;
                                o_result.kind = (i_state.token_number == 2'd0) ? KIND_METHOD
                                                                               : KIND_URI;
                                o_result.data = i_byte;
                                o_has_result  = 1'b1;
                            end
                        end
                    end
                end
                PH_HEAD: begin
                    if (w_crlf && i_state.term == TM_CRLFCR) begin
                        o_state.phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (32'(i_state.body_count) < BODY_BUFFER - 1) begin
                        o_state.body_count = i_state.body_count + 1'b1;
                        o_result.kind      = KIND_BODY;
                        o_result.data      = i_byte;
                        o_has_result       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* tb/tb.sv */
// Self-checking testbench for http_request_tokenizer: random and directed requests,
// a byte-level tokenizer model and an in-order comparison of every result item.
// Depends on hrt_pkg and the http_request_tokenizer RTL.
module tb;
    import hrt_pkg::*;

    localparam int HOLD_AT   = 150;
    localparam int HOLD_LEN  = 80;

    typedef struct {
        logic [7:0] data;
        bit         drain_first;
    } t_feed;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_result_kind;
    logic [7:0]            o_result_byte;
    logic                  o_malformed;
    logic [BODY_LEN_W-1:0] o_body_length;
    logic                  o_last;

    t_feed   request_bytes[$];
    t_result results_due[$];

    t_phase              ph_q = PH_LINE;
    logic [LINE_W-1:0]   line_cnt = '0;
    logic [1:0]          tok_num = 2'd0;
    logic [TLEN_W-1:0]   tok_len = '0;
    logic                in_tok = 1'b0;
    t_term               term_q = TM_NONE;
    logic [BODY_W-1:0]   body_cnt = '0;

    bit pause_next = 1'b0;
    bit in_taken = 1'b0;
    bit res_taken = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int send_wait = 0;
    int recv_wait = 0;
    int bytes_queued = 0;
    int requests_queued = 0;
    int bytes_in = 0;
    int results_seen = 0;
    int ok_seen = 0;
    int bad_seen = 0;
    int body_seen = 0;
    int fault_count = 0;

    http_request_tokenizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_result_byte (o_result_byte),
        .o_malformed   (o_malformed),
        .o_body_length (o_body_length),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // Advances the tokenizer by one byte; returns 1 when the byte yields a result item.
    function automatic bit parse_byte(input logic [7:0] b, output t_result r);
        t_term prev;
        bit    crlf;
        bit    bad;
        r = '0;
        prev = term_q;
        if (b == CH_NUL) begin
            bad = (ph_q == PH_LINE || ph_q == PH_BAD);
            r.kind = KIND_STATUS;
            r.malformed = bad;
            r.body_length = bad ? '0 : BODY_LEN_W'(body_cnt);
            r.last = 1'b1;
            ph_q = PH_LINE;
            line_cnt = '0;
            tok_num = 2'd0;
            tok_len = '0;
            in_tok = 1'b0;
            term_q = TM_NONE;
            body_cnt = '0;
            return 1'b1;
        end
        crlf = (b == CH_LF) && (prev == TM_CR || prev == TM_CRLFCR);
        if (b == CH_CR) begin
            term_q = (prev == TM_CRLF) ? TM_CRLFCR : TM_CR;
        end else if (b == CH_LF && prev == TM_CR) begin
            term_q = TM_CRLF;
        end else begin
            term_q = TM_NONE;
        end
        case (ph_q)
            PH_LINE: begin
                if (crlf) begin
                    if (in_tok) begin
                        tok_num++;
                        in_tok = 1'b0;
                    end
                    // The CR of the line end is part of the counted length.
                    ph_q = (line_cnt >= LINE_LIMIT + 1 || tok_num < 2'd2) ? PH_BAD : PH_HEAD;
                    return 1'b0;
                end
                if (line_cnt <= LINE_LIMIT)
                    line_cnt++;
                if (is_blank(b)) begin
                    if (in_tok) begin
                        tok_num++;
                        in_tok = 1'b0;
                    end
                    return 1'b0;
                end
                if (tok_num >= 2'd2)
                    return 1'b0;
                if (!in_tok) begin
                    in_tok = 1'b1;
                    tok_len = '0;
                end
                if (tok_len >= ((tok_num == 2'd0) ? METHOD_BUFFER - 1 : URI_BUFFER - 1)) begin
                    ph_q = PH_BAD;
                    return 1'b0;
                end
                tok_len++;
                r.kind = t_kind'(tok_num);
                r.data = b;
                return 1'b1;
            end
            PH_HEAD: begin
                if (crlf && prev == TM_CRLFCR)
                    ph_q = PH_BODY;
            end
            PH_BODY: begin
                if (body_cnt < BODY_BUFFER - 1) begin
                    body_cnt++;
                    r.kind = KIND_BODY;
                    r.data = b;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        request_bytes.push_back('{data: b, drain_first: pause_next});
        pause_next = 1'b0;
        bytes_queued++;
    endtask

    task automatic push_token(input int len);
        logic [7:0] c;
        repeat (len) begin
            do c = 8'($urandom_range(1, 255)); while (is_blank(c));
            push_byte(c);
        end
    endtask

    // Separators include a lone CR and a lone LF, which count as whitespace.
    task automatic push_sep();
        case ($urandom_range(0, 5))
            0: push_byte(CH_TAB);
            1: push_byte(8'h0B);
            2: push_byte(8'h0C);
            3: push_byte(CH_CR);
            4: push_byte(CH_LF);
            default: push_byte(CH_SPACE);
        endcase
        if ($urandom_range(0, 3) == 0)
            push_byte(CH_SPACE);
    endtask

    task automatic push_header();
        logic [7:0] c;
        repeat ($urandom_range(1, 10)) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_CR || c == CH_LF);
            push_byte(c);
        end
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    // A negative body length ends the request inside the header section.
    task automatic push_request(input int mlen, input int ulen, input int third,
                                input int hdrs, input int blen, input bit plain);
        push_token(mlen);
        if (plain)
            push_byte(CH_SPACE);
        else
            push_sep();
        push_token(ulen);
        if (third > 0) begin
            push_byte(CH_SPACE);
            push_token(third);
        end
        push_byte(CH_CR);
        push_byte(CH_LF);
        repeat (hdrs) push_header();
        if (blen >= 0) begin
            push_byte(CH_CR);
            push_byte(CH_LF);
            repeat (blen) push_byte(8'($urandom_range(1, 255)));
        end
        push_byte(CH_NUL);
        requests_queued++;
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        in_taken = 1'b0;
        res_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                in_taken = 1'b1;
                bytes_in++;
                if (parse_byte(i_data_byte, want))
                    results_due.push_back(want);
            end
            if (o_valid && i_ready) begin
                res_taken = 1'b1;
                results_seen++;
                if (o_result_kind == KIND_STATUS) begin
                    if (o_malformed)
                        bad_seen++;
                    else
                        ok_seen++;
                end else if (o_result_kind == KIND_BODY) begin
                    body_seen++;
                end
                if (results_due.size() == 0) begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                             $time, o_result_kind, o_result_byte);
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("result_byte", want.data, o_result_byte);
                    check_field("malformed", want.malformed, o_malformed);
                    check_field("body_length", want.body_length, o_body_length);
                    check_field("last", want.last, o_last);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        bit    drive;
        t_feed item;
        if (i_rst_n) begin
            drive = i_valid && !in_taken;
            if (in_taken && bytes_in % 64 == 0)
                send_calm = ($urandom_range(0, 2) == 0);
            if (!drive) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (request_bytes.size() != 0 &&
                             !(request_bytes[0].drain_first && results_due.size() != 0)) begin
                    item = request_bytes.pop_front();
                    i_data_byte <= item.data;
                    drive = 1'b1;
                    send_wait = send_calm ? 0 : $urandom_range(0, 6);
                end
            end
            i_valid <= drive;
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (res_taken) begin
                if (results_seen == HOLD_AT)
                    recv_wait = HOLD_LEN;
                else
                    recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
                if (results_seen % 48 == 0)
                    recv_calm = ($urandom_range(0, 2) == 0);
            end
            if (recv_wait > 0) begin
                i_ready <= 1'b0;
                recv_wait--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int n;
        int pick;
        int quiet;

        push_byte(CH_NUL);
        push_byte(8'h47);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_NUL);
        push_byte(8'hFF);
        push_byte(CH_TAB);
        push_byte(8'h41);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(8'h80);
        push_byte(CH_NUL);
        push_byte(8'h41);
        push_byte(CH_CR);
        push_byte(8'h42);
        push_byte(CH_LF);
        push_byte(8'h43);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_NUL);
        requests_queued += 4;

        for (n = 0; n < 6 || bytes_queued < 550; n++) begin
            if (n % 6 == 3)
                pause_next = 1'b1;
            case (n)
                2: push_request(15, 255, 16, 0, 2, 1'b1);
                default: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        push_request(($urandom_range(0, 9) == 0) ? 15 : $urandom_range(1, 8),
                                     ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, 16),
                                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0,
                                     $urandom_range(0, 2),
                                     ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 16),
                                     1'b0);
                    end else if (pick < 85) begin
                        case ($urandom_range(0, 4))
                            0: push_request($urandom_range(16, 18), $urandom_range(1, 8),
                                            0, 1, 2, 1'b0);
                            1: push_request($urandom_range(1, 6), $urandom_range(256, 258),
                                            0, 0, 2, 1'b0);
                            2: begin
                                push_token($urandom_range(0, 6));
                                push_byte(CH_CR);
                                push_byte(CH_LF);
                                push_byte(CH_CR);
                                push_byte(CH_LF);
                                push_byte(8'h78);
                                push_byte(CH_NUL);
                                requests_queued++;
                            end
                            3: begin
                                push_token($urandom_range(1, 6));
                                push_sep();
                                push_token($urandom_range(1, 6));
                                push_byte(CH_NUL);
                                requests_queued++;
                            end
                            default: begin
                                push_token($urandom_range(1, 6));
                                push_byte(CH_SPACE);
                                push_token($urandom_range(1, 6));
                                push_byte(CH_CR);
                                push_byte(CH_NUL);
                                requests_queued++;
                            end
                        endcase
                    end else begin
                        repeat ($urandom_range(0, 16)) push_byte(8'($urandom_range(1, 255)));
                        push_byte(CH_NUL);
                        requests_queued++;
                    end
                end
            endcase
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_bytes.size() != 0 || i_valid) @(posedge i_clk);
        quiet = 0;
        while (results_due.size() != 0 && quiet < 2000) begin
            @(posedge i_clk);
            quiet++;
        end
        repeat (8) @(posedge i_clk);
        if (results_due.size() != 0) begin
            fault_count++;
            $display("%0t: %0d expected results never arrived", $time, results_due.size());
        end

        $display("Sent %0d requests in %0d bytes and checked %0d result items.",
                 requests_queued, bytes_in, results_seen);
        $display("Statuses seen: %0d well formed, %0d malformed; body bytes passed: %0d.",
                 ok_seen, bad_seen, body_seen);
        if (fault_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hrt_pkg.sv
hdl/hrt_parse.sv
hdl/http_request_tokenizer.sv
tb/tb.sv
